// File: sv/dvru_pkg.sv
package dvru_pkg;

   localparam int unsigned COST_INFINITY = 16;
   localparam int unsigned COST_ADJACENT = 1;
   localparam int unsigned COST_W        = 5;
   localparam int unsigned ADDR_W        = 32;

   localparam logic MODE_ADVERTISED = 1'b0;
   localparam logic MODE_LOCAL      = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // one advertised entry as latched at the start of its table sweep
   typedef struct packed {
      logic                 mode;
      logic [ADDR_W-1:0]    adv_dest;
      logic [ADDR_W-1:0]    adv_interface;
      logic [COST_W-1:0]    adv_cost;
      logic [ADDR_W-1:0]    sender_addr;
      logic [ADDR_W-1:0]    recv_interface;
      logic                 last_entry;
   } item_type;

   // stored route, dest in the lowest bits
   typedef struct packed {
      logic [COST_W-1:0]    cost;
      logic [ADDR_W-1:0]    interface_addr;
      logic [ADDR_W-1:0]    next_hop;
      logic [ADDR_W-1:0]    dest;
   } route_type;

   // result flags, entry_changed in bit 0
   typedef struct packed {
      logic                 send_update;
      logic                 dropped_full;
      logic                 entry_changed;
   } result_type;

endpackage

// File: sv/distance_vector_route_update_top.sv
// Route table update for a distance-vector router.
// req channel: one advertised route entry per beat. tuser carries the mode
// (0 merge an advertised entry, 1 install a local route), tlast marks the
// final entry of an advertisement message.
// rsp channel: exactly one beat per request beat, in order, with the flags
// entry_changed, dropped_full and send_update (send_update only on tlast).
// Each entry sweeps the stored routes through one table RAM, one entry read
// per cycle with the compare on the registered read data. The sweep ends at
// the first stored route with a matching dest, or after the last stored route
// when none matches; the next request is taken only once the result has left
// for the output register.
// req_tready is high only while no entry is being worked on. A finished
// result sits in the output register; when the receiver stalls the block
// still takes one more request and holds its result until the register
// drains.
// Synchronous reset empties the table (fill count to zero) and clears the
// pending-change flag; route contents are not cleared.
module distance_vector_route_update_top #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // adv_dest[31:0], adv_interface[63:32], adv_cost[68:64],
   // sender_addr[100:69], recv_interface[132:101], zero pad
   input  logic [135:0]  req_tdata,
   // mode[0]
   input  logic [0:0]    req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // entry_changed[0], dropped_full[1], send_update[2], zero pad
   output logic [7:0]    rsp_tdata
);
   import dvru_pkg::*;

   item_type    item;
   result_type  res;
   logic        res_valid;
   logic        seq_ready;
   logic        slot_free;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   assign item.mode           = req_tuser[0];
   assign item.adv_dest       = req_tdata[31:0];
   assign item.adv_interface  = req_tdata[63:32];
   assign item.adv_cost       = req_tdata[68:64];
   assign item.sender_addr    = req_tdata[100:69];
   assign item.recv_interface = req_tdata[132:101];
   assign item.last_entry     = req_tlast;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = seq_ready;

   dvru_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && seq_ready),
      .item      (item),
      .slot_free (slot_free),
      .ready     (seq_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

endmodule

// File: sv/dvru_ram.sv
module dvru_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dvru_seq.sv
module dvru_seq #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dvru_pkg::item_type    item,
   input  logic                  slot_free,
   output logic                  ready,
   output logic                  res_valid,
   output dvru_pkg::result_type  res
);
   import dvru_pkg::*;

   localparam int unsigned IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNTW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned RW   = $bits(route_type);

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic [CNTW-1:0]  iss_ff, iss_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDXW-1:0]  chk_idx_ff, chk_idx_in;
   logic             wr_ff, wr_in;
   logic [IDXW-1:0]  wr_addr_ff, wr_addr_in;
   route_type        wr_data_ff, wr_data_in;
   logic             changed_ff, changed_in;
   logic             dropped_ff, dropped_in;
   logic             mm_ff, mm_in;

   logic [IDXW-1:0]  rd_addr;
   logic [RW-1:0]    rd_raw;
   route_type        rd_route;
   logic             hit;
   logic             issuing;
   logic [COST_W:0]  cost_sum;
   logic [COST_W-1:0] cost_adv;
   logic [COST_W-1:0] cost_local;
   logic [COST_W-1:0] cost_new;
   logic             adjacent;

   dvru_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (state_ff == ST_RESP && wr_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_route = route_type'(rd_raw);

   assign cost_sum   = {1'b0, item_ff.adv_cost} + (COST_W+1)'(1);
   assign cost_adv   = (cost_sum > (COST_W+1)'(COST_INFINITY)) ?
                       COST_W'(COST_INFINITY) : cost_sum[COST_W-1:0];
   assign cost_local = (item_ff.adv_cost > COST_W'(COST_INFINITY)) ?
                       COST_W'(COST_INFINITY) : item_ff.adv_cost;
   assign cost_new   = (item_ff.mode == MODE_LOCAL) ? cost_local : cost_adv;
   assign adjacent   = (item_ff.adv_dest == item_ff.adv_interface);

   // entries below the fill count are the valid ones, as routes are never removed
   assign issuing = (iss_ff != count_ff);
   assign hit     = chk_vld_ff && (rd_route.dest == item_ff.adv_dest);
   assign rd_addr = iss_ff[IDXW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
         wr_ff      <= 1'b0;
         mm_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
         wr_ff      <= wr_in;
         mm_ff      <= mm_in;
      end
      item_ff    <= item_in;
      iss_ff     <= iss_in;
      chk_idx_ff <= chk_idx_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      changed_ff <= changed_in;
      dropped_ff <= dropped_in;
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      count_in   = count_ff;
      iss_in     = iss_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      wr_in      = wr_ff;
      wr_addr_in = wr_addr_ff;
      wr_data_in = wr_data_ff;
      changed_in = changed_ff;
      dropped_in = dropped_ff;
      mm_in      = mm_ff;
      ready      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               item_in  = item;
               iss_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            wr_data_in.dest           = item_ff.adv_dest;
            wr_data_in.next_hop       = item_ff.sender_addr;
            wr_data_in.interface_addr = item_ff.recv_interface;
            wr_data_in.cost           = cost_new;
            dropped_in                = 1'b0;
            if (hit) begin
               // first matching route, decide on the data just read
               wr_addr_in = chk_idx_ff;
               state_in   = ST_RESP;
               if (item_ff.mode == MODE_LOCAL) begin
                  wr_in      = 1'b1;
                  changed_in = 1'b1;
               end else if (adjacent) begin
                  wr_data_in.cost = COST_W'(COST_ADJACENT);
                  wr_in           = 1'b1;
                  changed_in      = 1'b0;
               end else if (rd_route.cost > cost_adv ||
                            (rd_route.next_hop == item_ff.sender_addr &&
                             rd_route.cost != cost_adv)) begin
                  wr_in      = 1'b1;
                  changed_in = 1'b1;
               end else begin
                  wr_in      = 1'b0;
                  changed_in = 1'b0;
               end
            end else if (!issuing) begin
               state_in   = ST_RESP;
               wr_addr_in = count_ff[IDXW-1:0];
               if (count_ff < CNTW'(TABLE_ENTRIES)) begin
                  wr_in      = 1'b1;
                  changed_in = 1'b1;
                  count_in   = count_ff + CNTW'(1);
               end else begin
                  wr_in      = 1'b0;
                  changed_in = 1'b0;
                  dropped_in = 1'b1;
               end
            end else begin
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDXW-1:0];
               iss_in     = iss_ff + CNTW'(1);
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               res_valid         = 1'b1;
               res.entry_changed = changed_ff;
               res.dropped_full  = dropped_ff;
               res.send_update   = item_ff.last_entry && (mm_ff || changed_ff);
               mm_in             = item_ff.last_entry ? 1'b0 : (mm_ff || changed_ff);
               wr_in             = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(TABLE_ENTRIES))
      else $error("route count beyond table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == ST_SCAN &&
         count_ff == $past(count_ff) + CNTW'(1))
      else $error("route count moved outside an insert");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> iss_ff <= count_ff)
      else $error("sweep ran past the filled entries");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && start |=> state_ff == ST_SCAN)
      else $error("accepted beat did not start a sweep");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.dropped_full |-> count_ff == CNTW'(TABLE_ENTRIES) &&
         !res.entry_changed)
      else $error("insert dropped while table has room");

endmodule
